// ----- rtl/core/rab_pkg.sv -----
`default_nettype none

package rab_pkg;

    // Default geometry of the datapath.
    localparam int COORD_WIDTH_DEF    = 24;
    localparam int TRIG_FRAC_BITS_DEF = 14;

    // Sine and cosine registers are fixed 16-bit signed values.
    localparam int TRIG_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TRIG_W;

    localparam logic [CFG_IDX_W-1:0] REG_COS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Z = 3'd5;

    // Reset values: identity rotation.
    localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sd0;

    // Words the rotation pipeline and the queue may hold together.
    localparam int QUEUE_DEPTH = 8;

endpackage

`default_nettype wire

// ----- rtl/core/rab_rot_stage.sv -----
`default_nettype none

// One plane rotation: o_a = a*c - b*s, o_b = a*s + b*c, rounded half up
// to the coordinate format and saturated. Two register levels, no stall.
module rab_rot_stage #(
    parameter int BOX_W     = rab_pkg::COORD_WIDTH_DEF + 1,
    parameter int FRAC_BITS = rab_pkg::TRIG_FRAC_BITS_DEF,
    parameter int SIDE_W    = rab_pkg::COORD_WIDTH_DEF + 2
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic signed [BOX_W-1:0]          i_a,
    input  wire logic signed [BOX_W-1:0]          i_b,
    input  wire logic signed [rab_pkg::TRIG_W-1:0] i_cos,
    input  wire logic signed [rab_pkg::TRIG_W-1:0] i_sin,
    input  wire logic        [SIDE_W-1:0]         i_side,
    output logic                                  o_valid,
    output logic signed [BOX_W-1:0]               o_a,
    output logic signed [BOX_W-1:0]               o_b,
    output logic        [SIDE_W-1:0]              o_side
);

    localparam int PROD_W = BOX_W + rab_pkg::TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] RND_C   = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] BOX_MAX = (SUM_W'(1) <<< (BOX_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] BOX_MIN = -(SUM_W'(1) <<< (BOX_W - 1));

    logic                      r_v1;
    logic                      r_v2;
    logic signed [PROD_W-1:0]  r_ac;
    logic signed [PROD_W-1:0]  r_bs;
    logic signed [PROD_W-1:0]  r_as;
    logic signed [PROD_W-1:0]  r_bc;
    logic        [SIDE_W-1:0]  r_side1;
    logic        [SIDE_W-1:0]  r_side2;
    logic signed [BOX_W-1:0]   r_a;
    logic signed [BOX_W-1:0]   r_b;

    logic signed [SUM_W-1:0]   n_sum_a;
    logic signed [SUM_W-1:0]   n_sum_b;
    logic signed [SUM_W-1:0]   n_sh_a;
    logic signed [SUM_W-1:0]   n_sh_b;
    logic signed [BOX_W-1:0]   n_a;
    logic signed [BOX_W-1:0]   n_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Product level: sign-extend both operands so the full product is kept.
    always_ff @(posedge i_clk) begin
        r_ac    <= PROD_W'(i_a) * PROD_W'(i_cos);
        r_bs    <= PROD_W'(i_b) * PROD_W'(i_sin);
        r_as    <= PROD_W'(i_a) * PROD_W'(i_sin);
        r_bc    <= PROD_W'(i_b) * PROD_W'(i_cos);
        r_side1 <= i_side;
    end

    // Sum, round, floor shift, saturate.
    always_comb begin
        n_sum_a = SUM_W'(r_ac) - SUM_W'(r_bs) + RND_C;
        n_sum_b = SUM_W'(r_as) + SUM_W'(r_bc) + RND_C;
        n_sh_a  = n_sum_a >>> FRAC_BITS;
        n_sh_b  = n_sum_b >>> FRAC_BITS;
        if (n_sh_a > BOX_MAX) begin
            n_a = BOX_MAX[BOX_W-1:0];
        end else if (n_sh_a < BOX_MIN) begin
            n_a = BOX_MIN[BOX_W-1:0];
        end else begin
            n_a = n_sh_a[BOX_W-1:0];
        end
        if (n_sh_b > BOX_MAX) begin
            n_b = BOX_MAX[BOX_W-1:0];
        end else if (n_sh_b < BOX_MIN) begin
            n_b = BOX_MIN[BOX_W-1:0];
        end else begin
            n_b = n_sh_b[BOX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_side2 <= r_side1;
    end

    assign o_valid = r_v2;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_side  = r_side2;

endmodule

`default_nettype wire

// ----- rtl/core/rab_front.sv -----
`default_nettype none

// Front end: trig registers, input credit check and the three rotation stages.
module rab_front #(
    parameter int COORD_WIDTH    = rab_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = rab_pkg::TRIG_FRAC_BITS_DEF,
    parameter int DEPTH          = rab_pkg::QUEUE_DEPTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [rab_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [rab_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]        i_vertex_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_vertex_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_vertex_z,
    input  wire logic                                 i_last_vertex,
    input  wire logic                                 i_pop,
    output logic                                      o_push,
    output logic [3*(COORD_WIDTH+1):0]                o_item
);

    localparam int BOX_W  = COORD_WIDTH + 1;
    localparam int SIDE_W = BOX_W + 1;
    localparam int OCC_W  = $clog2(DEPTH + 1);

    logic signed [rab_pkg::TRIG_W-1:0] r_cos_x, r_sin_x;
    logic signed [rab_pkg::TRIG_W-1:0] r_cos_y, r_sin_y;
    logic signed [rab_pkg::TRIG_W-1:0] r_cos_z, r_sin_z;
    logic        [OCC_W-1:0]           r_occ;
    logic        [OCC_W-1:0]           n_occ;
    logic                              accept;

    logic                     vx, vy, vz;
    logic signed [BOX_W-1:0]  y1, z1, z2, x2, rx, ry;
    logic        [SIDE_W-1:0] side_x, side_y, side_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_x <= rab_pkg::COS_RESET;
            r_sin_x <= rab_pkg::SIN_RESET;
            r_cos_y <= rab_pkg::COS_RESET;
            r_sin_y <= rab_pkg::SIN_RESET;
            r_cos_z <= rab_pkg::COS_RESET;
            r_sin_z <= rab_pkg::SIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rab_pkg::REG_COS_X: r_cos_x <= i_cfg_data;
                rab_pkg::REG_SIN_X: r_sin_x <= i_cfg_data;
                rab_pkg::REG_COS_Y: r_cos_y <= i_cfg_data;
                rab_pkg::REG_SIN_Y: r_sin_y <= i_cfg_data;
                rab_pkg::REG_COS_Z: r_cos_z <= i_cfg_data;
                rab_pkg::REG_SIN_Z: r_sin_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Words in flight through the stages plus words in the queue.
    assign o_in_ready = (r_occ < OCC_W'(DEPTH));
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_occ = r_occ;
        if (accept && !i_pop) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (!accept && i_pop) begin
            n_occ = r_occ - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign side_x = {BOX_W'(i_vertex_x), i_last_vertex};

    rab_rot_stage #(
        .BOX_W(BOX_W), .FRAC_BITS(TRIG_FRAC_BITS), .SIDE_W(SIDE_W)
    ) u_rot_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_a(BOX_W'(i_vertex_y)), .i_b(BOX_W'(i_vertex_z)),
        .i_cos(r_cos_x), .i_sin(r_sin_x), .i_side(side_x),
        .o_valid(vx), .o_a(y1), .o_b(z1), .o_side(side_y)
    );

    rab_rot_stage #(
        .BOX_W(BOX_W), .FRAC_BITS(TRIG_FRAC_BITS), .SIDE_W(SIDE_W)
    ) u_rot_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(vx),
        .i_a(z1), .i_b(side_y[SIDE_W-1:1]),
        .i_cos(r_cos_y), .i_sin(r_sin_y), .i_side({y1, side_y[0]}),
        .o_valid(vy), .o_a(z2), .o_b(x2), .o_side(side_z)
    );

    rab_rot_stage #(
        .BOX_W(BOX_W), .FRAC_BITS(TRIG_FRAC_BITS), .SIDE_W(SIDE_W)
    ) u_rot_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(vy),
        .i_a(x2), .i_b(side_z[SIDE_W-1:1]),
        .i_cos(r_cos_z), .i_sin(r_sin_z), .i_side({z2, side_z[0]}),
        .o_valid(vz), .o_a(rx), .o_b(ry), .o_side(o_item[SIDE_W-1:0])
    );

    assign o_push = vz;
    assign o_item[3*BOX_W:SIDE_W] = {rx, ry};

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("front: occupancy above queue depth");
    a_occ_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_occ != '0)
        else $error("front: pop with no word outstanding");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/rab_fifo.sv -----
`default_nettype none

// Queue of rotated points between front and back.
module rab_fifo #(
    parameter int WIDTH = 3 * (rab_pkg::COORD_WIDTH_DEF + 1) + 1,
    parameter int DEPTH = rab_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CNT_W'(DEPTH)) || i_pop)
        else $error("fifo: push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("fifo: pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/rab_back.sv -----
`default_nettype none

// Back end: running bounds, then centre and size into the output register.
module rab_back #(
    parameter int COORD_WIDTH = rab_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire logic [3*(COORD_WIDTH+1):0]    i_q_data,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [COORD_WIDTH:0]        o_center_x,
    output logic signed [COORD_WIDTH:0]        o_center_y,
    output logic signed [COORD_WIDTH:0]        o_center_z,
    output logic        [COORD_WIDTH:0]        o_size_x,
    output logic        [COORD_WIDTH:0]        o_size_y,
    output logic        [COORD_WIDTH:0]        o_size_z
);

    localparam int BOX_W = COORD_WIDTH + 1;

    logic                    r_first;
    logic                    r_fin;
    logic                    r_out_valid;
    logic signed [BOX_W-1:0] r_lo [3];
    logic signed [BOX_W-1:0] r_hi [3];
    logic signed [BOX_W-1:0] r_center [3];
    logic        [BOX_W-1:0] r_size [3];

    logic signed [BOX_W-1:0] pt [3];
    logic                    last;
    logic                    fin_move;
    logic signed [BOX_W:0]   n_sum [3];
    logic signed [BOX_W:0]   n_diff [3];

    assign pt[0] = i_q_data[3*BOX_W:2*BOX_W+1];
    assign pt[1] = i_q_data[2*BOX_W:BOX_W+1];
    assign pt[2] = i_q_data[BOX_W:1];
    assign last  = i_q_data[0];

    assign fin_move = r_fin && (!r_out_valid || i_out_ready);
    assign o_pop    = i_q_valid && (!r_fin || fin_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b1;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_first <= last;
            end
            if (o_pop && last) begin
                r_fin <= 1'b1;
            end else if (fin_move) begin
                r_fin <= 1'b0;
            end
            if (fin_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        always_ff @(posedge i_clk) begin
            if (o_pop) begin
                if (r_first || pt[k] < r_lo[k]) begin
                    r_lo[k] <= pt[k];
                end
                if (r_first || pt[k] > r_hi[k]) begin
                    r_hi[k] <= pt[k];
                end
            end
        end

        assign n_sum[k]  = (BOX_W + 1)'(r_lo[k]) + (BOX_W + 1)'(r_hi[k]);
        assign n_diff[k] = (BOX_W + 1)'(r_hi[k]) - (BOX_W + 1)'(r_lo[k]);

        always_ff @(posedge i_clk) begin
            if (fin_move) begin
                r_center[k] <= n_sum[k][BOX_W:1];
                r_size[k]   <= n_diff[k][BOX_W-1:0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_center_x  = r_center[0];
    assign o_center_y  = r_center[1];
    assign o_center_z  = r_center[2];
    assign o_size_x    = r_size[0];
    assign o_size_y    = r_size[1];
    assign o_size_z    = r_size[2];

`ifndef NO_ASSERTIONS
    a_bounds_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin && !fin_move |=> $stable(r_lo[0]) && $stable(r_hi[0])
                               && $stable(r_lo[2]) && $stable(r_hi[2]))
        else $error("back: bounds changed while a box is pending");
    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && last |=> r_first && r_fin)
        else $error("back: last word did not rearm");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo[1] > r_hi[1] |-> r_first && !r_fin)
        else $error("back: live bounds inverted");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/rotated_aabb_fit_core.sv -----
`default_nettype none
// The last vertex word passes the rotation registers and the queue and updates the bounds; then
// centre and size are registered and the box becomes valid. Throughput: one vertex word per cycle,
// bounded by the min/max update; the input stalls only when the queue credits run out.
// Reset (i_rst_n low, synchronous) restores the identity rotation and empties the pipeline,
// the queue and the output register; the next vertex seeds new bounds.

module rotated_aabb_fit_core #(
    parameter int COORD_WIDTH    = rab_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = rab_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [rab_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rab_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // vertex channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]      i_vertex_x,
    input  wire logic signed [COORD_WIDTH-1:0]      i_vertex_y,
    input  wire logic signed [COORD_WIDTH-1:0]      i_vertex_z,
    input  wire logic                               i_last_vertex,
    // box channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [COORD_WIDTH:0]             o_center_x,
    output logic signed [COORD_WIDTH:0]             o_center_y,
    output logic signed [COORD_WIDTH:0]             o_center_z,
    output logic        [COORD_WIDTH:0]             o_size_x,
    output logic        [COORD_WIDTH:0]             o_size_y,
    output logic        [COORD_WIDTH:0]             o_size_z
);

    // Queue word: rotated x, rotated y, rotated z, last flag.
    localparam int ITEM_W = 3 * (COORD_WIDTH + 1) + 1;

    logic              push;
    logic              pop;
    logic              q_valid;
    logic [ITEM_W-1:0] push_item;
    logic [ITEM_W-1:0] q_item;

    // Front: hold the trig values, rotate about X, then Y, then Z. A vertex
    // is taken only while the stages plus the queue have a free slot, so the
    // stages themselves never stall.
    rab_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
        .DEPTH(rab_pkg::QUEUE_DEPTH)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_vertex_x(i_vertex_x),
        .i_vertex_y(i_vertex_y),
        .i_vertex_z(i_vertex_z),
        .i_last_vertex(i_last_vertex),
        .i_pop(pop),
        .o_push(push),
        .o_item(push_item)
    );

    // Queue: decouple the rotation stages from the bounds and the output stall.
    rab_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(rab_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_data(push_item),
        .i_pop(pop),
        .o_valid(q_valid),
        .o_data(q_item)
    );

    // Back: advance the bounds one word per cycle; after the last word, register
    // centre and size into the output register once it is free. Drop back
    // pressure onto the queue only while a finished box cannot move out.
    rab_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data(q_item),
        .o_pop(pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_center_x(o_center_x),
        .o_center_y(o_center_y),
        .o_center_z(o_center_z),
        .o_size_x(o_size_x),
        .o_size_y(o_size_y),
        .o_size_z(o_size_z)
    );

endmodule

`default_nettype wire

// ----- test/rotated_aabb_fit_checker.sv -----
`default_nettype none

module rotated_aabb_fit_checker
    import rab_pkg::*;
(
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]               i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]              i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_ready,
    input  wire logic signed [COORD_WIDTH_DEF-1:0]  i_vertex_x,
    input  wire logic signed [COORD_WIDTH_DEF-1:0]  i_vertex_y,
    input  wire logic signed [COORD_WIDTH_DEF-1:0]  i_vertex_z,
    input  wire logic                               i_last_vertex,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic [COORD_WIDTH_DEF:0]           i_center_x,
    input  wire logic [COORD_WIDTH_DEF:0]           i_center_y,
    input  wire logic [COORD_WIDTH_DEF:0]           i_center_z,
    input  wire logic [COORD_WIDTH_DEF:0]           i_size_x,
    input  wire logic [COORD_WIDTH_DEF:0]           i_size_y,
    input  wire logic [COORD_WIDTH_DEF:0]           i_size_z,
    output int                                      o_mismatches,
    output int                                      o_pending
);

    localparam int     COORD_W = COORD_WIDTH_DEF;
    localparam int     BOX_W   = COORD_W + 1;
    localparam int     FRAC    = TRIG_FRAC_BITS_DEF;
    localparam longint BOX_HI  = (longint'(1) << COORD_W) - 1;
    localparam longint BOX_LO  = -(longint'(1) << COORD_W);

    typedef struct {
        logic [BOX_W-1:0] center_x;
        logic [BOX_W-1:0] center_y;
        logic [BOX_W-1:0] center_z;
        logic [BOX_W-1:0] size_x;
        logic [BOX_W-1:0] size_y;
        logic [BOX_W-1:0] size_z;
    } t_box;

    logic signed [TRIG_W-1:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
    bit     seed_bounds;
    longint low_x, high_x, low_y, high_y, low_z, high_z;
    t_box   expected_boxes[$];

    // a*c + b*d, rounded half up to signed Q25.0 and clamped to the box range
    function automatic longint rotate_term(longint a, longint c, longint b, longint d);
        longint acc;
        acc = a * c + b * d + (longint'(1) << (FRAC - 1));
        acc = acc >>> FRAC;
        if (acc > BOX_HI) return BOX_HI;
        if (acc < BOX_LO) return BOX_LO;
        return acc;
    endfunction

    function automatic logic [BOX_W-1:0] box_bits(longint v);
        return v[BOX_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] box mismatch: %s", $realtime, msg);
        o_mismatches++;
    endtask

    task automatic check_field(string name, logic [BOX_W-1:0] got, logic [BOX_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge i_clk) begin : predict
        longint vx, vy, vz, y1, z1, x2, z2, rx, ry;
        t_box   box;
        if (!i_rst_n) begin
            cos_x = COS_RESET; sin_x = SIN_RESET;
            cos_y = COS_RESET; sin_y = SIN_RESET;
            cos_z = COS_RESET; sin_z = SIN_RESET;
            seed_bounds = 1'b1;
            expected_boxes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_COS_X: cos_x = $signed(i_cfg_data);
                    REG_SIN_X: sin_x = $signed(i_cfg_data);
                    REG_COS_Y: cos_y = $signed(i_cfg_data);
                    REG_SIN_Y: sin_y = $signed(i_cfg_data);
                    REG_COS_Z: cos_z = $signed(i_cfg_data);
                    REG_SIN_Z: sin_z = $signed(i_cfg_data);
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_boxes.size() == 0) begin
                    report_mismatch($sformatf("unexpected box center %h/%h/%h",
                                              i_center_x, i_center_y, i_center_z));
                end else begin
                    box = expected_boxes.pop_front();
                    check_field("center_x", i_center_x, box.center_x);
                    check_field("center_y", i_center_y, box.center_y);
                    check_field("center_z", i_center_z, box.center_z);
                    check_field("size_x", i_size_x, box.size_x);
                    check_field("size_y", i_size_y, box.size_y);
                    check_field("size_z", i_size_z, box.size_z);
                end
            end

            if (i_in_valid && i_in_ready) begin
                vx = i_vertex_x;
                vy = i_vertex_y;
                vz = i_vertex_z;
                y1 = rotate_term(vy, cos_x, vz, -longint'(sin_x));
                z1 = rotate_term(vy, sin_x, vz, cos_x);
                z2 = rotate_term(z1, cos_y, vx, -longint'(sin_y));
                x2 = rotate_term(z1, sin_y, vx, cos_y);
                rx = rotate_term(x2, cos_z, y1, -longint'(sin_z));
                ry = rotate_term(x2, sin_z, y1, cos_z);
                if (seed_bounds) begin
                    low_x = rx; high_x = rx;
                    low_y = ry; high_y = ry;
                    low_z = z2; high_z = z2;
                    seed_bounds = 1'b0;
                end else begin
                    if (rx < low_x)  low_x = rx;
                    if (rx > high_x) high_x = rx;
                    if (ry < low_y)  low_y = ry;
                    if (ry > high_y) high_y = ry;
                    if (z2 < low_z)  low_z = z2;
                    if (z2 > high_z) high_z = z2;
                end
                if (i_last_vertex) begin
                    box.center_x = box_bits((low_x + high_x) >>> 1);
                    box.center_y = box_bits((low_y + high_y) >>> 1);
                    box.center_z = box_bits((low_z + high_z) >>> 1);
                    box.size_x   = box_bits(high_x - low_x);
                    box.size_y   = box_bits(high_y - low_y);
                    box.size_z   = box_bits(high_z - low_z);
                    expected_boxes.insert(expected_boxes.size(), box);
                    seed_bounds = 1'b1;
                end
            end
        end
        o_pending <= expected_boxes.size();
    end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none

module testbench;
    import rab_pkg::*;

    localparam int COORD_W     = COORD_WIDTH_DEF;
    localparam int BOX_W       = COORD_W + 1;
    // extra wait after the last expected box shows up, as margin
    localparam int DRAIN_CYCLES = 16;
    localparam int SET_VERTICES = 140;
    localparam int PHASES       = 10;

    localparam logic signed [COORD_W-1:0] COORD_TOP    = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_BOTTOM = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [TRIG_W-1:0] Q_ONE       = 16'h4000;
    localparam logic [TRIG_W-1:0] Q_NEG_ONE   = 16'hC000;
    localparam logic [TRIG_W-1:0] Q_ZERO      = 16'h0000;
    localparam logic [TRIG_W-1:0] TRIG_TOP    = 16'h7FFF;
    localparam logic [TRIG_W-1:0] TRIG_BOTTOM = 16'h8000;

    // indexes past the last register; the block must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_idx   = REG_COS_X;
    logic [CFG_DATA_W-1:0]     cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] vertex_x  = '0;
    logic signed [COORD_W-1:0] vertex_y  = '0;
    logic signed [COORD_W-1:0] vertex_z  = '0;
    logic                      last_flag = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [BOX_W-1:0]   center_x, center_y, center_z;
    logic        [BOX_W-1:0]   size_x, size_y, size_z;
    int                        mismatches;
    int                        pending;
    int                        ready_hold = 0;

    always #5 clk = ~clk;

    rotated_aabb_fit_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_vertex_x    (vertex_x),
        .i_vertex_y    (vertex_y),
        .i_vertex_z    (vertex_z),
        .i_last_vertex (last_flag),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_center_x    (center_x),
        .o_center_y    (center_y),
        .o_center_z    (center_z),
        .o_size_x      (size_x),
        .o_size_y      (size_y),
        .o_size_z      (size_z)
    );

    rotated_aabb_fit_checker box_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_vertex_x    (vertex_x),
        .i_vertex_y    (vertex_y),
        .i_vertex_z    (vertex_z),
        .i_last_vertex (last_flag),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_center_x    (center_x),
        .i_center_y    (center_y),
        .i_center_z    (center_z),
        .i_size_x      (size_x),
        .i_size_y      (size_y),
        .i_size_z      (size_z),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Set length: mostly a handful of vertices, sometimes many.
    function automatic int pick_set_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(1, 4);
        if (r < 9) return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    // Coordinates: extremes, values near zero, and plain random bit patterns.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int          r;
        int          near;
        logic [31:0] bits;
        r = $urandom_range(0, 9);
        near = $urandom_range(0, 8192) - 4096;
        bits = $urandom();
        case (r)
            0: return COORD_TOP;
            1: return COORD_BOTTOM;
            2: return near[COORD_W-1:0];
            default: return bits[COORD_W-1:0];
        endcase
    endfunction

    // Trig values: unit-range angles mostly, with some raw 16-bit patterns
    // to exercise gains above one and the saturation of each stage.
    function automatic logic [TRIG_W-1:0] pick_trig();
        int          r;
        int          unit;
        logic [31:0] bits;
        r = $urandom_range(0, 9);
        unit = $urandom_range(0, 32768) - 16384;
        bits = $urandom();
        case (r)
            0: return TRIG_TOP;
            1: return TRIG_BOTTOM;
            2, 3: return bits[TRIG_W-1:0];
            default: return unit[TRIG_W-1:0];
        endcase
    endfunction

    // Receiver: alternate ready runs and stalls of random length. Long runs
    // give stretches where the box channel never pushes back.
    always @(negedge clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (out_ready) begin
            out_ready  <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(10, 40);
        end else begin
            out_ready  <= 1'b1;
            ready_hold <= ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4)
                                                     : $urandom_range(30, 80);
        end
    end

    // Offer one vertex word and hold it until the block takes it. Valid only
    // drops when a pause comes first, so back-to-back words keep it high.
    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z,
                               input logic                      closes_set);
        int gap;
        gap = pick_pause();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        vertex_x  <= x;
        vertex_y  <= y;
        vertex_z  <= z;
        last_flag <= closes_set;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stream random sets; always close the final set so nothing is left open
    // when the rotation changes.
    task automatic run_sets(input int count);
        int left;
        left = 0;
        for (int i = 0; i < count; i++) begin
            if (left == 0) left = pick_set_len();
            left--;
            send_vertex(pick_coord(), pick_coord(), pick_coord(),
                        (left == 0) || (i == count - 1));
        end
    endtask

    // Drop valid, wait for every expected box, then let the pipeline empty.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TRIG_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
    endtask

    // Program all six registers back to back, poke the unused indexes, then
    // drop the write enable.
    task automatic write_rotation(input logic [TRIG_W-1:0] cx, input logic [TRIG_W-1:0] sx,
                                  input logic [TRIG_W-1:0] cy, input logic [TRIG_W-1:0] sy,
                                  input logic [TRIG_W-1:0] cz, input logic [TRIG_W-1:0] sz);
        write_reg(REG_COS_X, cx);
        write_reg(REG_SIN_X, sx);
        write_reg(REG_COS_Y, cy);
        write_reg(REG_SIN_Y, sy);
        write_reg(REG_COS_Z, cz);
        write_reg(REG_SIN_Z, sz);
        write_reg(REG_SPARE_A, pick_trig());
        write_reg(REG_SPARE_B, pick_trig());
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Identity rotation out of reset: plain box fit.
        // Single-vertex sets: center is the point, size is zero.
        send_vertex(COORD_TOP, COORD_BOTTOM, '0, 1'b1);
        send_vertex(COORD_BOTTOM, COORD_TOP, -24'sd1, 1'b1);
        // Opposite corners: widest possible box.
        send_vertex(COORD_TOP, COORD_TOP, COORD_TOP, 1'b0);
        send_vertex(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 1'b1);
        // Small set around the origin, symmetric in x and y.
        send_vertex(24'sd1, -24'sd1, 24'sd0, 1'b0);
        send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_vertex(-24'sd1, 24'sd1, 24'sd1, 1'b1);
        // Odd negative sums: center must round toward minus infinity.
        send_vertex(-24'sd1, -24'sd2, -24'sd3, 1'b0);
        send_vertex(24'sd0, -24'sd1, -24'sd2, 1'b1);
        // Interior points must not move the bounds.
        send_vertex(24'sd5, 24'sd5, 24'sd5, 1'b0);
        send_vertex(24'sd3, 24'sd3, 24'sd3, 1'b0);
        send_vertex(24'sd9, 24'sd9, 24'sd9, 1'b0);
        send_vertex(24'sd7, 24'sd7, 24'sd7, 1'b1);

        run_sets(SET_VERTICES);

        for (int phase = 1; phase < PHASES; phase++) begin
            settle();
            case (phase)
                1: write_rotation(Q_ZERO, Q_ONE, Q_ZERO, Q_ONE, Q_ZERO, Q_ONE);
                2: write_rotation(Q_NEG_ONE, Q_ZERO, Q_NEG_ONE, Q_ZERO, Q_NEG_ONE, Q_ZERO);
                3: write_rotation(Q_ZERO, Q_NEG_ONE, Q_ZERO, Q_NEG_ONE, Q_ZERO, Q_NEG_ONE);
                4: write_rotation(TRIG_TOP, TRIG_TOP, TRIG_TOP, TRIG_TOP, TRIG_TOP, TRIG_TOP);
                5: write_rotation(TRIG_BOTTOM, TRIG_BOTTOM, TRIG_BOTTOM,
                                  TRIG_BOTTOM, TRIG_BOTTOM, TRIG_BOTTOM);
                6: write_rotation(TRIG_BOTTOM, TRIG_TOP, TRIG_BOTTOM,
                                  TRIG_TOP, TRIG_BOTTOM, TRIG_TOP);
                default: write_rotation(pick_trig(), pick_trig(), pick_trig(),
                                        pick_trig(), pick_trig(), pick_trig());
            endcase
            run_sets(SET_VERTICES);
        end

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
